/* hdl/stri_pkg.sv */
package stri_pkg;

  localparam int MAX_DIGIT_SYMBOLS = 16;
  localparam int SYM_W             = 8;
  localparam int SYMS_W            = MAX_DIGIT_SYMBOLS * SYM_W;
  localparam int COUNT_W           = 5;
  localparam int VALUE_W           = 32;
  localparam int DIGIT_W           = $clog2(MAX_DIGIT_SYMBOLS);

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [1:0] REG_SYMS_LOW    = 2'd1;
  localparam logic [1:0] REG_SYMS_HIGH   = 2'd2;

  localparam logic [COUNT_W-1:0]    RST_DIGIT_COUNT = 5'd10;
  localparam logic [CFG_DATA_W-1:0] RST_SYMS_LOW    = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] RST_SYMS_HIGH   = 64'h0000_0000_0000_3938;

  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CHAR_FF    = 8'h0c;
  localparam logic [SYM_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [SYM_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [SYM_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CHAR_VT    = 8'h0b;

  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // configuration as seen by the parser
  typedef struct packed {
    logic [SYMS_W-1:0]  symbols;     // symbol i in bits [8i+7:8i]
    logic [COUNT_W-1:0] used_count;  // radix, clamped to MAX_DIGIT_SYMBOLS
    logic               digits_invalid;
  } cfg_t;

endpackage

/* hdl/stri_cfg.sv */
module stri_cfg
  import stri_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [COUNT_W-1:0]    digit_count, digit_count_next;
  logic [CFG_DATA_W-1:0] syms_low, syms_low_next;
  logic [CFG_DATA_W-1:0] syms_high, syms_high_next;
  logic                  bad;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  function automatic logic digits_bad(logic [COUNT_W-1:0] cnt, logic [SYMS_W-1:0] syms);
    logic             res;
    logic [SYM_W-1:0] si;
    res = (cnt < COUNT_W'(2)) || (cnt > COUNT_W'(MAX_DIGIT_SYMBOLS));
    for (int i = 0; i < MAX_DIGIT_SYMBOLS; i++) begin
      si = syms[SYM_W*i +: SYM_W];
      if (COUNT_W'(i) < cnt) begin
        if (si == CHAR_NUL || si == CHAR_PLUS || si == CHAR_MINUS) res = 1'b1;
        for (int j = i + 1; j < MAX_DIGIT_SYMBOLS; j++) begin
          if (COUNT_W'(j) < cnt && syms[SYM_W*j +: SYM_W] == si) res = 1'b1;
        end
      end
    end
    return res;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    digit_count_next = digit_count;
    syms_low_next    = syms_low;
    syms_high_next   = syms_high;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DIGIT_COUNT: digit_count_next = pwdata[COUNT_W-1:0];
        REG_SYMS_LOW:    syms_low_next    = pwdata;
        REG_SYMS_HIGH:   syms_high_next   = pwdata;
        default: ;
      endcase
    end
  end

  // validity flag follows the written values with no extra cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= RST_DIGIT_COUNT;
      syms_low    <= RST_SYMS_LOW;
      syms_high   <= RST_SYMS_HIGH;
      bad         <= digits_bad(RST_DIGIT_COUNT, {RST_SYMS_HIGH, RST_SYMS_LOW});
    end else begin
      digit_count <= digit_count_next;
      syms_low    <= syms_low_next;
      syms_high   <= syms_high_next;
      bad         <= digits_bad(digit_count_next, {syms_high_next, syms_low_next});
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIGIT_COUNT: prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, digit_count};
      REG_SYMS_LOW:    prdata = syms_low;
      REG_SYMS_HIGH:   prdata = syms_high;
      default:         prdata = '0;
    endcase
  end

  assign cfg.symbols        = {syms_high, syms_low};
  assign cfg.used_count     = (digit_count > COUNT_W'(MAX_DIGIT_SYMBOLS)) ?
                              COUNT_W'(MAX_DIGIT_SYMBOLS) : digit_count;
  assign cfg.digits_invalid = bad;

endmodule

/* hdl/string_to_int_custom_radix_core.sv */
// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/s_tready s_tdata[7:0] = char_code
// m_*       out  m_tvalid/m_tready m_tdata[31:0] = value, m_tuser[0] = digits_invalid
// apb       in   psel/penable      registers at 0x00, 0x08, 0x10
//
// One word per cycle unless a zero word is held back: input register -> digit match, multiply-add -> result register.
// An accepted zero word passes through the input register, then sets m_tvalid in the result register.
// Only a zero word produces a result; it waits in stage 1 while the result
// register is full and not taken, otherwise every word moves on each cycle.
// Synchronous reset clears the parse state, valids and restores the default digits.
module string_to_int_custom_radix_core
  import stri_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SYM_W-1:0]      s_tdata,   // [7:0] char_code
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VALUE_W-1:0]    m_tdata,   // [31:0] value
  output logic                  m_tuser,   // [0] digits_invalid
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  logic               in_valid;
  logic [SYM_W-1:0]   in_char;
  logic               in_end;
  logic               out_free;
  logic               advance;

  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [VALUE_W-1:0] acc, acc_next;

  logic [MAX_DIGIT_SYMBOLS-1:0] match;
  logic                         hit;
  logic [DIGIT_W-1:0]           digit;
  logic [VALUE_W+COUNT_W-1:0]   product;
  logic                         is_space, is_sign;
  logic [VALUE_W-1:0]           result;

  stri_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_end   = (in_char == CHAR_NUL);
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_end || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DIGIT_SYMBOLS; i++) begin
      match[i] = (COUNT_W'(i) < cfg.used_count) &&
                 (cfg.symbols[SYM_W*i +: SYM_W] == in_char);
    end
  end

  // lowest matching index wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_DIGIT_SYMBOLS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit   = 1'b1;
        digit = DIGIT_W'(i);
      end
    end
  end

  assign product  = acc * cfg.used_count;
  assign is_space = (in_char == CHAR_SPACE) || (in_char == CHAR_FF) ||
                    (in_char == CHAR_LF) || (in_char == CHAR_CR) ||
                    (in_char == CHAR_TAB) || (in_char == CHAR_VT);
  assign is_sign  = (in_char == CHAR_PLUS) || (in_char == CHAR_MINUS);
  assign result   = cfg.digits_invalid ? '0 : (negative ? (VALUE_W'(0) - acc) : acc);

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    acc_next      = acc;
    if (in_end) begin
      phase_next    = PH_SPACE;
      negative_next = 1'b0;
      acc_next      = '0;
    end else if (phase != PH_DONE) begin
      priority if (hit) begin
        acc_next   = product[VALUE_W-1:0] + VALUE_W'(digit);
        phase_next = PH_DIGIT;
      end else if (phase == PH_SPACE && is_space) begin
        phase_next = PH_SPACE;
      end else if ((phase == PH_SPACE || phase == PH_SIGN) && is_sign) begin
        if (in_char == CHAR_MINUS) negative_next = !negative;
        phase_next = PH_SIGN;
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      negative <= 1'b0;
      acc      <= '0;
    end else if (advance) begin
      phase    <= phase_next;
      negative <= negative_next;
      acc      <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && in_end) begin
      m_tdata <= result;
      m_tuser <= cfg.digits_invalid;
    end
  end

endmodule

/* dv/stri_scoreboard.sv */
module stri_scoreboard
  import stri_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [SYM_W-1:0]      s_tdata,   // [7:0] char_code
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [VALUE_W-1:0]    m_tdata,   // [31:0] value
  input  logic                  m_tuser,   // [0] digits_invalid
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               digits_invalid;
  } parsed_t;

  logic [COUNT_W-1:0] radix;
  logic [SYMS_W-1:0]  symbols;
  phase_t             cur_phase;
  logic               negative;
  logic [VALUE_W-1:0] magnitude;
  parsed_t            parsed_due[$];
  int                 fail_count;

  assign errors = fail_count;

  function automatic int radix_in_use();
    return (radix > MAX_DIGIT_SYMBOLS) ? MAX_DIGIT_SYMBOLS : int'(radix);
  endfunction

  // lowest matching index wins when a symbol repeats
  function automatic int digit_of(logic [SYM_W-1:0] c);
    for (int i = 0; i < radix_in_use(); i++)
      if (symbols[i*SYM_W +: SYM_W] == c) return i;
    return -1;
  endfunction

  function automatic bit is_blank(logic [SYM_W-1:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
           c == CHAR_VT || c == CHAR_FF || c == CHAR_CR;
  endfunction

  function automatic bit symbol_set_bad();
    logic [SYM_W-1:0] s;
    if (radix < 2 || radix > MAX_DIGIT_SYMBOLS) return 1'b1;
    for (int i = 0; i < int'(radix); i++) begin
      s = symbols[i*SYM_W +: SYM_W];
      if (s == CHAR_NUL || s == CHAR_PLUS || s == CHAR_MINUS) return 1'b1;
      for (int j = i + 1; j < int'(radix); j++)
        if (symbols[j*SYM_W +: SYM_W] == s) return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    parsed_t want;
    int      d;
    int      pushed;
    int      popped;
    bit      bad;
    pushed = 0;
    popped = 0;
    if (rst) begin
      radix     = RST_DIGIT_COUNT;
      symbols   = {RST_SYMS_HIGH, RST_SYMS_LOW};
      cur_phase = PH_SPACE;
      negative  = 1'b0;
      magnitude = '0;
      parsed_due.delete();
      pending  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (parsed_due.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR %0t: result with nothing expected, value %0d flag %0b",
                     $realtime, $signed(m_tdata), m_tuser);
          fail_count++;
        end else begin
          want   = parsed_due.pop_front();
          popped = 1;
          if (m_tdata !== want.value || m_tuser !== want.digits_invalid) begin
            if (fail_count < 10)
              $display("ERROR %0t: expected value %0d flag %0b, got value %0d flag %0b",
                       $realtime, $signed(want.value), want.digits_invalid,
                       $signed(m_tdata), m_tuser);
            fail_count++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tdata == CHAR_NUL) begin
          bad = symbol_set_bad();
          want.value          = bad ? '0 : (negative ? -magnitude : magnitude);
          want.digits_invalid = bad;
          parsed_due.push_back(want);
          pushed    = 1;
          cur_phase = PH_SPACE;
          negative  = 1'b0;
          magnitude = '0;
        end else if (cur_phase != PH_DONE) begin
          d = digit_of(s_tdata);
          if (d >= 0) begin
            magnitude = magnitude * VALUE_W'(radix_in_use()) + VALUE_W'(d);
            cur_phase = PH_DIGIT;
          end else if (cur_phase == PH_SPACE && is_blank(s_tdata)) begin
            cur_phase = PH_SPACE;
          end else if ((cur_phase == PH_SPACE || cur_phase == PH_SIGN) &&
                       (s_tdata == CHAR_PLUS || s_tdata == CHAR_MINUS)) begin
            if (s_tdata == CHAR_MINUS) negative = ~negative;
            cur_phase = PH_SIGN;
          end else begin
            cur_phase = PH_DONE;
          end
        end
      end

      // applied after the word of this edge, which saw the old setting
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:3])
          REG_DIGIT_COUNT: radix = pwdata[COUNT_W-1:0];
          REG_SYMS_LOW:    symbols[CFG_DATA_W-1:0] = pwdata;
          REG_SYMS_HIGH:   symbols[SYMS_W-1:CFG_DATA_W] = pwdata;
          default: ;
        endcase
      end

      pending <= parsed_due.size();
    end
  end

endmodule

/* dv/tb.sv */
module tb;
  import stri_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // decodes to no register

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SYM_W-1:0]      s_tdata;   // [7:0] char_code
  logic                  m_tvalid;
  logic                  m_tready;
  logic [VALUE_W-1:0]    m_tdata;   // [31:0] value
  logic                  m_tuser;   // [0] digits_invalid
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int pending;

  // digit set as last written, used to build strings
  int               gen_count;
  logic [SYM_W-1:0] gen_syms[16];
  int               chars_sent;
  bit               no_idle;

  string_to_int_custom_radix_core dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  stri_scoreboard scoreboard (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin : watchdog
    #5_000_000;
    $display("string_to_int_custom_radix_core: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SYM_W-1:0] blank_char();
    case ($urandom_range(0, 5))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_LF;
      3:       return CHAR_VT;
      4:       return CHAR_FF;
      default: return CHAR_CR;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] sign_char();
    return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
  endfunction

  function automatic logic [SYM_W-1:0] digit_char();
    int n;
    n = (gen_count > MAX_DIGIT_SYMBOLS) ? MAX_DIGIT_SYMBOLS : gen_count;
    if (n == 0) return SYM_W'($urandom_range(1, 255));
    return gen_syms[$urandom_range(0, n - 1)];
  endfunction

  // distinct legal symbols in the used slots, anything at all above them
  function automatic void make_set(input int cnt, input bit with_blanks);
    logic [SYM_W-1:0] c;
    bit               clash;
    gen_count = cnt;
    for (int i = 0; i < 16; i++) gen_syms[i] = SYM_W'($urandom_range(0, 255));
    for (int i = 0; i < cnt && i < 16; i++) begin
      do begin
        c = (with_blanks && i < 2) ? blank_char() : SYM_W'($urandom_range(1, 255));
        clash = (c == CHAR_PLUS || c == CHAR_MINUS);
        for (int j = 0; j < i; j++)
          if (gen_syms[j] == c) clash = 1'b1;
      end while (clash);
      gen_syms[i] = c;
    end
  endfunction

  task automatic put_char(input logic [SYM_W-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_digits();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = gen_syms[i];
      hi[8*i +: 8] = gen_syms[i+8];
    end
    // junk above the count field must not matter
    reg_write(REG_DIGIT_COUNT, {$urandom(), 27'($urandom()), COUNT_W'(gen_count)});
    reg_write(REG_SYMS_LOW, lo);
    reg_write(REG_SYMS_HIGH, hi);
  endtask

  // mostly well-formed strings; some broken by a stray word, some pure noise
  task automatic send_string(input bit whole);
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      n = $urandom_range(0, 6);
      repeat (n) put_char(SYM_W'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) put_char(blank_char());
      if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 3)) put_char(sign_char());
      if (kind >= 7)
        put_char($urandom_range(0, 1) ? blank_char() : SYM_W'($urandom_range(1, 255)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
      repeat (n) put_char(digit_char());
      if (whole && $urandom_range(0, 1))
        repeat ($urandom_range(1, 3)) put_char(SYM_W'($urandom_range(1, 255)));
    end
    if (whole) put_char(CHAR_NUL);
  endtask

  task automatic run_strings(input int budget);
    int start;
    start = chars_sent;
    while (chars_sent - start < budget) begin
      no_idle = ($urandom_range(0, 9) == 0);
      send_string(1'b1);
      if ($urandom_range(0, 29) == 0) settle();
    end
    no_idle = 1'b0;
  endtask

  initial begin : sink
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      n = no_idle ? 1 : $urandom_range(1, 6);
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    string decimal;
    int    cnt;
    int    i;
    int    j;
    decimal    = "0123456789abcdef";
    chars_sent = 0;
    no_idle    = 1'b0;
    gen_count  = RST_DIGIT_COUNT;
    for (int k = 0; k < 8; k++) begin
      gen_syms[k]   = RST_SYMS_LOW[8*k +: 8];
      gen_syms[k+8] = RST_SYMS_HIGH[8*k +: 8];
    end
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings on the default decimal set
    put_char(CHAR_NUL);
    put_char(CHAR_SPACE);
    put_char(CHAR_TAB);
    put_char(CHAR_LF);
    put_char(CHAR_VT);
    put_char(CHAR_FF);
    put_char(CHAR_CR);
    send_text("-+-7x3");
    put_char(CHAR_NUL);
    send_text("- 5");        // blank after a sign ends the parse
    put_char(CHAR_NUL);
    send_text("-9999999999"); // wraps
    put_char(CHAR_NUL);
    put_char(8'hff);
    send_text("7");
    put_char(CHAR_NUL);

    for (int k = 0; k < 10; k++) begin
      settle();
      case (k)
        0: begin
          make_set(10, 1'b0);
          for (i = 0; i < 10; i++) gen_syms[i] = decimal[i];
          reg_write(REG_SPARE, {$urandom(), $urandom()});
        end
        1: begin
          make_set(16, 1'b0);
          for (i = 0; i < 16; i++) gen_syms[i] = decimal[i];
        end
        2: make_set(2, 1'b0);
        3: make_set($urandom_range(3, 15), 1'b0);
        4: make_set($urandom_range(4, 12), 1'b1);
        5: make_set($urandom_range(0, 1), 1'b0);
        6: make_set($urandom_range(17, 31), 1'b0);
        7: begin
          cnt = $urandom_range(3, 16);
          make_set(cnt, 1'b0);
          i = $urandom_range(0, cnt - 2);
          j = $urandom_range(i + 1, cnt - 1);
          gen_syms[j] = gen_syms[i];
        end
        8: begin
          cnt = $urandom_range(2, 16);
          make_set(cnt, 1'b0);
          case ($urandom_range(0, 2))
            0:       gen_syms[$urandom_range(0, cnt - 1)] = CHAR_NUL;
            1:       gen_syms[$urandom_range(0, cnt - 1)] = CHAR_PLUS;
            default: gen_syms[$urandom_range(0, cnt - 1)] = CHAR_MINUS;
          endcase
        end
        default: make_set(16, 1'b0);
      endcase
      load_digits();
      run_strings((k >= 5 && k <= 8) ? 80 : 220);
      // leave a string open across the next digit set change
      send_string(1'b0);
    end

    put_char(CHAR_NUL);
    settle();
    if (errors == 0) begin
      $display("string_to_int_custom_radix_core: match");
    end else begin
      $display("string_to_int_custom_radix_core: mismatch");
    end
    $finish;
  end

endmodule
